// ===== rtl/ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared types and constants of the overcurrent fault supervisor.
// ----------------------------------------------------------------------------
package ofs_pkg;

  localparam int unsigned LimitW   = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StepW    = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgNominalLimit       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaximumLimit       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNominalLimitHoming = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaximumLimitHoming = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOvercurrentTicks   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRecoveryTicks      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFaultHoldTicks     = 3'd6;

  localparam logic [TicksW-1:0] FaultHoldReset = 16'd100;

  // Step codes as reported on the result word
  localparam logic [StepW-1:0] StepCodeIdle     = 2'd0;
  localparam logic [StepW-1:0] StepCodeTiming   = 2'd1;
  localparam logic [StepW-1:0] StepCodeShutdown = 2'd2;
  localparam logic [StepW-1:0] StepCodeRecover  = 2'd3;

  typedef enum logic [3:0] {
    StIdle     = 4'b0001,
    StTiming   = 4'b0010,
    StShutdown = 4'b0100,
    StRecover  = 4'b1000
  } step_e;

  typedef struct packed {
    logic [LimitW-1:0] nominal_limit;
    logic [LimitW-1:0] maximum_limit;
    logic [LimitW-1:0] nominal_limit_homing;
    logic [LimitW-1:0] maximum_limit_homing;
    logic [TicksW-1:0] overcurrent_ticks;
    logic [TicksW-1:0] recovery_ticks;
    logic [TicksW-1:0] fault_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic request_maximum;
    logic request_nominal;
    logic fault_pin;
    logic homing;
  } item_t;

  typedef struct packed {
    logic [StepW-1:0]  sequence_step;
    logic              shutdown_enabled;
    logic [LimitW-1:0] maximum_value;
    logic              write_maximum;
    logic [LimitW-1:0] nominal_value;
    logic              write_nominal;
  } result_t;

endpackage

// ===== rtl/overcurrent_fault_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// overcurrent_fault_supervisor_top
// Overcurrent fault supervisor: one tick per input word, one result word per
// tick with the current-limit writes, the shutdown mapping and the step.
//
//   channel   dir   width  contents
//   s_axis    in    8      tick: homing, fault_pin, request_nominal,
//                          request_maximum
//   m_axis    out   24     result: write flags, limit values, shutdown, step
//   cfg       in    16     register writes, index 0..6
//
// A word taken in is held in the input register, then the tick logic updates
// the state and loads the output register, which offers the result word; one
// word per cycle is sustained while m_axis_tready is high. The output register
// stalls on m_axis_tready and the input register refills in the same cycle the
// output drains. Reset clears the valid flags, the state and the config, but
// sets shutdown and loads fault_hold_ticks with FaultHoldReset.
// ----------------------------------------------------------------------------
module overcurrent_fault_supervisor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] homing, [1] fault_pin, [2] request_nominal,
  //        [3] request_maximum, [7:4] zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // tdata: [0] write_nominal, [8:1] nominal_value, [9] write_maximum,
  //        [17:10] maximum_value, [18] shutdown_enabled,
  //        [20:19] sequence_step, [23:21] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ofs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ofs_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  ofs_pkg::cfg_t    cfg_q;
  ofs_pkg::item_t   item_q;
  logic             in_valid_q;
  ofs_pkg::result_t res_d, res_q;
  logic             out_valid_q;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{nominal_limit:        '0,
                 maximum_limit:        '0,
                 nominal_limit_homing: '0,
                 maximum_limit_homing: '0,
                 overcurrent_ticks:    '0,
                 recovery_ticks:       '0,
                 fault_hold_ticks:     ofs_pkg::FaultHoldReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ofs_pkg::CfgNominalLimit:
          cfg_q.nominal_limit <= cfg_wdata_i[ofs_pkg::LimitW-1:0];
        ofs_pkg::CfgMaximumLimit:
          cfg_q.maximum_limit <= cfg_wdata_i[ofs_pkg::LimitW-1:0];
        ofs_pkg::CfgNominalLimitHoming:
          cfg_q.nominal_limit_homing <= cfg_wdata_i[ofs_pkg::LimitW-1:0];
        ofs_pkg::CfgMaximumLimitHoming:
          cfg_q.maximum_limit_homing <= cfg_wdata_i[ofs_pkg::LimitW-1:0];
        ofs_pkg::CfgOvercurrentTicks:
          cfg_q.overcurrent_ticks <= cfg_wdata_i[ofs_pkg::TicksW-1:0];
        ofs_pkg::CfgRecoveryTicks:
          cfg_q.recovery_ticks <= cfg_wdata_i[ofs_pkg::TicksW-1:0];
        ofs_pkg::CfgFaultHoldTicks:
          cfg_q.fault_hold_ticks <= cfg_wdata_i[ofs_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Move a word from the input register when the output register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= ofs_pkg::item_t'(s_axis_tdata[3:0]);
    end
  end

  ofs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

endmodule

// ===== rtl/ofs_core.sv =====
// ----------------------------------------------------------------------------
// ofs_core
// Supervisor state and the logic of one tick: timers, limit writes and the
// four-step fault sequence. State advances when advance_i is high.
// ----------------------------------------------------------------------------
module ofs_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  ofs_pkg::item_t  item_i,
  input  ofs_pkg::cfg_t   cfg_i,
  output ofs_pkg::result_t result_o
);

  ofs_pkg::step_e                   step_q, step_d;
  logic                             was_homing_q;
  logic [ofs_pkg::TicksW-1:0]       oc_timer_q, oc_timer_d;
  logic [ofs_pkg::TicksW-1:0]       hold_timer_q, hold_timer_d;
  logic                             shutdown_q, shutdown_d;

  logic                             mode_change;
  logic                             wr_nom;
  logic                             wr_max;
  logic [ofs_pkg::TicksW-1:0]       oc_dec;
  logic [ofs_pkg::TicksW-1:0]       hold_dec;
  ofs_pkg::step_e                   step_pre;
  logic [ofs_pkg::StepW-1:0]        step_code;

  // Step both timers down, stopping at zero
  assign oc_dec   = (oc_timer_q == '0) ? '0 : oc_timer_q - 1'b1;
  assign hold_dec = (hold_timer_q == '0) ? '0 : hold_timer_q - 1'b1;

  // Limit writes on a mode change or a request
  assign mode_change = item_i.homing ^ was_homing_q;
  assign wr_nom      = item_i.request_nominal | mode_change;
  assign wr_max      = item_i.request_maximum | mode_change;
  assign step_pre    = wr_nom ? ofs_pkg::StIdle : step_q;

  // Run the fault sequence
  always_comb begin
    step_d       = step_pre;
    oc_timer_d   = oc_dec;
    hold_timer_d = hold_dec;
    shutdown_d   = shutdown_q;
    case (step_pre)
      ofs_pkg::StIdle: begin
        shutdown_d = 1'b0;
        if (item_i.fault_pin) begin
          oc_timer_d = cfg_i.overcurrent_ticks;
          step_d     = ofs_pkg::StTiming;
        end
      end
      ofs_pkg::StTiming: begin
        if (item_i.fault_pin) begin
          hold_timer_d = cfg_i.fault_hold_ticks;
        end
        if (oc_dec == '0) begin
          // Expiry advances one step from wherever the hold check left it
          shutdown_d = 1'b1;
          step_d     = (item_i.fault_pin || hold_dec != '0) ? ofs_pkg::StShutdown
                                                            : ofs_pkg::StTiming;
        end else if (!item_i.fault_pin && hold_dec == '0) begin
          step_d = ofs_pkg::StIdle;
        end
      end
      ofs_pkg::StShutdown: begin
        if (!item_i.fault_pin) begin
          oc_timer_d = cfg_i.recovery_ticks;
          step_d     = ofs_pkg::StRecover;
        end
      end
      ofs_pkg::StRecover: begin
        if (item_i.fault_pin) begin
          step_d = ofs_pkg::StShutdown;
        end else if (oc_dec == '0) begin
          step_d = ofs_pkg::StIdle;
        end
      end
      default: begin
        step_d = ofs_pkg::StIdle;
      end
    endcase
  end

  // Encode the step for the result word
  always_comb begin
    case (step_d)
      ofs_pkg::StIdle:     step_code = ofs_pkg::StepCodeIdle;
      ofs_pkg::StTiming:   step_code = ofs_pkg::StepCodeTiming;
      ofs_pkg::StShutdown: step_code = ofs_pkg::StepCodeShutdown;
      ofs_pkg::StRecover:  step_code = ofs_pkg::StepCodeRecover;
      default:             step_code = ofs_pkg::StepCodeIdle;
    endcase
  end

  // Build the result
  always_comb begin
    result_o.write_nominal    = wr_nom;
    result_o.nominal_value    = !wr_nom ? '0 :
                                item_i.homing ? cfg_i.nominal_limit_homing
                                              : cfg_i.nominal_limit;
    result_o.write_maximum    = wr_max;
    result_o.maximum_value    = !wr_max ? '0 :
                                item_i.homing ? cfg_i.maximum_limit_homing
                                              : cfg_i.maximum_limit;
    result_o.shutdown_enabled = shutdown_d;
    result_o.sequence_step    = step_code;
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ofs_pkg::StIdle;
      was_homing_q <= 1'b0;
      oc_timer_q   <= '0;
      hold_timer_q <= '0;
      shutdown_q   <= 1'b1;
    end else if (advance_i) begin
      step_q       <= step_d;
      was_homing_q <= item_i.homing;
      oc_timer_q   <= oc_timer_d;
      hold_timer_q <= hold_timer_d;
      shutdown_q   <= shutdown_d;
    end
  end

endmodule
